// ===== src/cpu_alu_with_flags_assert.svh =====
// Assertion macros shared by the ALU checker.
`ifndef CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Same-cycle implication.
`define CAF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ALU check failed");

// Next-cycle implication.
`define CAF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ALU check failed");

`endif

// ===== src/caf_pkg.sv =====
// Shared types and constants for the 8-bit ALU with Z N H C flags.
`timescale 1ns / 1ps

package caf_pkg;

   // flag vector bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   typedef enum logic [4:0] {
      CMD_ADD     = 5'd0,
      CMD_ADC     = 5'd1,
      CMD_SUB     = 5'd2,
      CMD_SBC     = 5'd3,
      CMD_AND     = 5'd4,
      CMD_XOR     = 5'd5,
      CMD_OR      = 5'd6,
      CMD_CP      = 5'd7,
      CMD_INC     = 5'd8,
      CMD_DEC     = 5'd9,
      CMD_RLC     = 5'd10,
      CMD_RRC     = 5'd11,
      CMD_RL      = 5'd12,
      CMD_RR      = 5'd13,
      CMD_SLA     = 5'd14,
      CMD_SRA     = 5'd15,
      CMD_SRL     = 5'd16,
      CMD_SWAP    = 5'd17,
      CMD_BIT     = 5'd18,
      CMD_RES     = 5'd19,
      CMD_SET     = 5'd20,
      CMD_CCF     = 5'd21,
      CMD_SCF     = 5'd22,
      CMD_CPL     = 5'd23,
      CMD_RLCA    = 5'd24,
      CMD_RRCA    = 5'd25,
      CMD_RLA     = 5'd26,
      CMD_RRA     = 5'd27,
      CMD_ADD_HL  = 5'd28,
      CMD_ADD_SP  = 5'd29,
      CMD_LOAD_A  = 5'd30,
      CMD_LOAD_AF = 5'd31
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [7:0]         operand;
      logic [2:0]         bit_index;
      logic [15:0]        wide_base;
      logic [15:0]        wide_operand;
      logic signed [7:0]  offset;
   } item_type;

   typedef struct packed {
      logic [7:0]  acc_out;
      logic [3:0]  flags_out;
      logic [7:0]  target_out;
      logic [15:0] wide_out;
   } result_type;

endpackage

// ===== src/caf_exec.sv =====
// Combinational ALU: one command against the current accumulator and flags.
`timescale 1ns / 1ps

module caf_exec (
   input  caf_pkg::item_type   item,
   input  logic [7:0]          acc,
   input  logic [3:0]          flags,
   output caf_pkg::result_type res
);
   import caf_pkg::*;

   logic        cin;
   logic        cf;
   logic        zf;
   logic [8:0]  sum9;
   logic [4:0]  sum5;
   logic [8:0]  dif9;
   logic [4:0]  dif5;
   logic [7:0]  v;
   logic [7:0]  a;
   logic [7:0]  t;
   logic [7:0]  logic_r;
   logic [16:0] hl17;
   logic [12:0] hl13;
   logic [15:0] sp_ext;
   logic [4:0]  sp5;
   logic [8:0]  sp9;
   logic [7:0]  off_u;

   always_comb begin
      v      = item.operand;
      a      = acc;
      cf     = flags[FLAG_C];
      zf     = flags[FLAG_Z];
      off_u  = $unsigned(item.offset);
      cin    = ((item.cmd == CMD_ADC) || (item.cmd == CMD_SBC)) ? cf : 1'b0;

      sum9   = {1'b0, a} + {1'b0, v} + {8'd0, cin};
      sum5   = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
      dif9   = {1'b0, a} - {1'b0, v} - {8'd0, cin};
      dif5   = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};

      hl17   = {1'b0, item.wide_base} + {1'b0, item.wide_operand};
      hl13   = {1'b0, item.wide_base[11:0]} + {1'b0, item.wide_operand[11:0]};
      sp_ext = {{8{off_u[7]}}, off_u};
      sp5    = {1'b0, item.wide_base[3:0]} + {1'b0, off_u[3:0]};
      sp9    = {1'b0, item.wide_base[7:0]} + {1'b0, off_u};

      logic_r = a & v;
      t       = v;

      res.acc_out    = acc;
      res.flags_out  = flags;
      res.target_out = v;
      res.wide_out   = 16'd0;

      case (item.cmd)
         CMD_ADD, CMD_ADC: begin
            res.acc_out   = sum9[7:0];
            res.flags_out = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
         end
         CMD_SUB, CMD_SBC: begin
            res.acc_out   = dif9[7:0];
            res.flags_out = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
         end
         CMD_CP: begin
            res.flags_out = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
         end
         CMD_AND: begin
            logic_r       = a & v;
            res.acc_out   = logic_r;
            res.flags_out = {logic_r == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         CMD_XOR: begin
            logic_r       = a ^ v;
            res.acc_out   = logic_r;
            res.flags_out = {logic_r == 8'd0, 3'b000};
         end
         CMD_OR: begin
            logic_r       = a | v;
            res.acc_out   = logic_r;
            res.flags_out = {logic_r == 8'd0, 3'b000};
         end
         CMD_INC: begin
            t              = v + 8'd1;
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 1'b0, v[3:0] == 4'hF, cf};
         end
         CMD_DEC: begin
            t              = v - 8'd1;
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 1'b1, v[3:0] == 4'h0, cf};
         end
         CMD_RLC: begin
            t              = {v[6:0], v[7]};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[7]};
         end
         CMD_RRC: begin
            t              = {v[0], v[7:1]};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[0]};
         end
         CMD_RL: begin
            t              = {v[6:0], cf};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[7]};
         end
         CMD_RR: begin
            t              = {cf, v[7:1]};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[0]};
         end
         CMD_SLA: begin
            t              = {v[6:0], 1'b0};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[7]};
         end
         CMD_SRA: begin
            t              = {v[7], v[7:1]};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[0]};
         end
         CMD_SRL: begin
            t              = {1'b0, v[7:1]};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 2'b00, v[0]};
         end
         CMD_SWAP: begin
            t              = {v[3:0], v[7:4]};
            res.target_out = t;
            res.flags_out  = {t == 8'd0, 3'b000};
         end
         CMD_BIT: begin
            res.flags_out = {~v[item.bit_index], 1'b0, 1'b1, cf};
         end
         CMD_RES: begin
            t                 = v;
            t[item.bit_index] = 1'b0;
            res.target_out    = t;
         end
         CMD_SET: begin
            t                 = v;
            t[item.bit_index] = 1'b1;
            res.target_out    = t;
         end
         CMD_CCF: res.flags_out = {zf, 2'b00, ~cf};
         CMD_SCF: res.flags_out = {zf, 2'b00, 1'b1};
         CMD_CPL: begin
            res.acc_out   = ~a;
            res.flags_out = {zf, 1'b1, 1'b1, cf};
         end
         // accumulator rotates always clear Z
         CMD_RLCA: begin
            res.acc_out   = {a[6:0], a[7]};
            res.flags_out = {3'b000, a[7]};
         end
         CMD_RRCA: begin
            res.acc_out   = {a[0], a[7:1]};
            res.flags_out = {3'b000, a[0]};
         end
         CMD_RLA: begin
            res.acc_out   = {a[6:0], cf};
            res.flags_out = {3'b000, a[7]};
         end
         CMD_RRA: begin
            res.acc_out   = {cf, a[7:1]};
            res.flags_out = {3'b000, a[0]};
         end
         CMD_ADD_HL: begin
            res.wide_out  = hl17[15:0];
            res.flags_out = {zf, 1'b0, hl13[12], hl17[16]};
         end
         // H and C come from the unsigned low-byte add, not the signed sum
         CMD_ADD_SP: begin
            res.wide_out  = item.wide_base + sp_ext;
            res.flags_out = {2'b00, sp5[4], sp9[8]};
         end
         CMD_LOAD_A: res.acc_out = v;
         CMD_LOAD_AF: begin
            res.acc_out   = item.wide_operand[15:8];
            res.flags_out = item.wide_operand[7:4];
         end
         default: begin
            res.acc_out   = acc;
            res.flags_out = flags;
         end
      endcase
   end

endmodule

// ===== src/cpu_alu_with_flags.sv =====
// Top level: 8-bit ALU with accumulator, Z N H C flags and item pipeline.
`timescale 1ns / 1ps

// Takes one command item per clock while not stalled and returns one result
// item for each, in order. An accepted item is held in an input register,
// goes through the single-stage ALU and lands in the result register, from
// which it can be taken when the output side is not stalled.
// Accumulator and flags update at the edge the item leaves the input
// register, so the next item sees them at once: the loop from flag and
// accumulator registers through one pass of the ALU sets the rate of one
// item per cycle. A stalled result holds, and one more item waits in the
// input register before req_stall rises. Reset clears accumulator and flags.
module cpu_alu_with_flags (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  caf_pkg::cmd_type       req_cmd,
   input  logic [7:0]             req_operand,
   input  logic [2:0]             req_bit_index,
   input  logic [15:0]            req_wide_base,
   input  logic [15:0]            req_wide_operand,
   input  logic signed [7:0]      req_offset,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_acc_out,
   output logic [3:0]             rsp_flags_out,
   output logic [7:0]             rsp_target_out,
   output logic [15:0]            rsp_wide_out
);
   import caf_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   in_item_ff;
   item_type   in_item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_res_ff;
   result_type out_res_in;
   logic [7:0] acc_ff;
   logic [7:0] acc_in;
   logic [3:0] flags_ff;
   logic [3:0] flags_in;

   logic       out_free;
   logic       fire;
   logic       accept;
   result_type alu_res;

   caf_exec u_exec (
      .item  (in_item_ff),
      .acc   (acc_ff),
      .flags (flags_ff),
      .res   (alu_res)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      fire      = in_valid_ff && out_free;
      req_stall = in_valid_ff && !out_free;
      accept    = req_valid && !req_stall;

      in_valid_in  = accept || (in_valid_ff && !fire);
      in_item_in   = accept ? item_type'{cmd: req_cmd, operand: req_operand,
                                          bit_index: req_bit_index,
                                          wide_base: req_wide_base,
                                          wide_operand: req_wide_operand,
                                          offset: req_offset} : in_item_ff;
      out_valid_in = fire || (out_valid_ff && rsp_stall);
      out_res_in   = fire ? alu_res : out_res_ff;
      acc_in       = fire ? alu_res.acc_out : acc_ff;
      flags_in     = fire ? alu_res.flags_out : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         acc_ff       <= 8'd0;
         flags_ff     <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
         flags_ff     <= flags_in;
      end
      in_item_ff <= in_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_acc_out    = out_res_ff.acc_out;
   assign rsp_flags_out  = out_res_ff.flags_out;
   assign rsp_target_out = out_res_ff.target_out;
   assign rsp_wide_out   = out_res_ff.wide_out;

endmodule

// ===== src/caf_checker.sv =====
// Port-level checker for the ALU top level, with its bind.
`timescale 1ns / 1ps
`include "cpu_alu_with_flags_assert.svh"

module caf_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [7:0]             rsp_acc_out,
   input logic [3:0]             rsp_flags_out,
   input logic [7:0]             rsp_target_out,
   input logic [15:0]            rsp_wide_out
);

   // a stalled result stays offered
   `CAF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled result keeps its payload
   `CAF_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable({rsp_acc_out, rsp_flags_out, rsp_target_out, rsp_wide_out}))

   // input side only backs up when a result is waiting and blocked
   `CAF_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // pipeline comes out of reset empty
   `CAF_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall)

   // an item taken while the output is empty shows a result once it has passed the input and result registers
   `CAF_ASSERT_NXT(a_fill, clock, reset, req_valid && !req_stall && !rsp_valid,
                   ##1 rsp_valid)

endmodule

bind cpu_alu_with_flags caf_checker u_caf_checker (.*);
